// ===== hw/rtl/vadt_pkg.sv =====
`default_nettype none

package vadt_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH = 4096;
  localparam int INDEX_WIDTH = 17;
  localparam int KEY_W       = 3 * INDEX_WIDTH;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_INDEX_W = 12;

  typedef logic [INDEX_WIDTH-1:0] index_t;
  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [OUT_INDEX_W-1:0] out_index_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the key and restart the scan
    logic scan;         // issue the next read and compare the previous one
    logic report_hit;   // deliver the matching position
    logic append;       // store the key at the end and deliver its position
    logic report_full;  // deliver a table-full result
  } vadt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // the entry just compared matches the key
    logic scan_end;  // every stored entry has been compared without a match
    logic full;      // no room left to append
  } vadt_status_t;

  // Low bits of a table position, zero-extended when the table is small.
  function automatic out_index_t to_out_index(input addr_t pos);
    logic [31:0] wide;
    wide = 32'(pos);
    return wide[OUT_INDEX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vadt_ram.sv =====
`default_nettype none

module vadt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vadt_ctrl.sv =====
`default_nettype none

module vadt_ctrl
  import vadt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire vadt_status_t status,
  output vadt_cmd_t         cmd,
  output logic              busy
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          cmd.report_hit = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (status.scan_end) begin
          if (status.full) begin
            cmd.report_full = 1'b1;
          end else begin
            cmd.append = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/vadt_datapath.sv =====
`default_nettype none

module vadt_datapath
  import vadt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire vadt_cmd_t   cmd,
  input  wire index_t      vertex_index,
  input  wire index_t      texcoord_index,
  input  wire index_t      normal_index,
  output vadt_status_t     status,
  output logic             res_valid,
  output out_index_t       res_index,
  output logic             res_inserted,
  output logic             res_full
);

  key_t   key_r;
  count_t count_r;
  count_t count_nxt;
  count_t rd_addr_r;
  count_t rd_addr_nxt;
  addr_t  cmp_addr_r;
  logic   cmp_valid_r;
  logic   cmp_valid_nxt;
  logic   issue;
  key_t   rdata;
  logic   ram_we;

  logic       valid_r;
  out_index_t index_r;
  logic       inserted_r;
  logic       full_r;

  // A read is issued while the scan pointer is below the fill count.
  assign issue  = cmd.scan && (rd_addr_r < count_r);
  assign ram_we = cmd.append;

  vadt_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[ADDR_W-1:0]),
    .wdata(key_r),
    .raddr(rd_addr_r[ADDR_W-1:0]),
    .rdata(rdata)
  );

  assign status.hit      = cmp_valid_r && (rdata == key_r);
  assign status.scan_end = !issue && !cmp_valid_r;
  assign status.full     = (count_r == count_t'(TABLE_DEPTH));

  always_comb begin
    rd_addr_nxt   = rd_addr_r;
    cmp_valid_nxt = 1'b0;
    count_nxt     = count_r;
    if (cmd.load) begin
      rd_addr_nxt = '0;
    end else if (issue) begin
      rd_addr_nxt   = rd_addr_r + count_t'(1);
      cmp_valid_nxt = 1'b1;
    end
    if (cmd.append) begin
      count_nxt = count_r + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      valid_r     <= cmd.report_hit || cmd.append || cmd.report_full;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    cmp_addr_r <= rd_addr_r[ADDR_W-1:0];
    if (cmd.load) begin
      key_r <= {normal_index, texcoord_index, vertex_index};
    end
    if (cmd.report_hit) begin
      index_r    <= to_out_index(cmp_addr_r);
      inserted_r <= 1'b0;
      full_r     <= 1'b0;
    end else if (cmd.append) begin
      index_r    <= to_out_index(count_r[ADDR_W-1:0]);
      inserted_r <= 1'b1;
      full_r     <= 1'b0;
    end else if (cmd.report_full) begin
      index_r    <= '0;
      inserted_r <= 1'b0;
      full_r     <= 1'b1;
    end
  end

  assign res_valid    = valid_r;
  assign res_index    = index_r;
  assign res_inserted = inserted_r;
  assign res_full     = full_r;

endmodule

`default_nettype wire

// ===== hw/rtl/vertex_attribute_dedup_table_unit.sv =====
// Vertex attribute deduplication table. Each transaction carries a key of
// vertex, texture-coordinate and normal index (17-bit two's complement,
// with -1 for an absent attribute, compared as raw bit patterns). A
// transaction is accepted when start is high while busy is low. The key is
// compared against the stored keys in order of position; the first match
// returns its position, a miss appends the key and returns the new position
// with out_was_inserted set, and a miss on a full table (4096 entries)
// returns position 0 with out_table_full set and stores nothing. The result
// appears for exactly one cycle with out_valid high, and busy drops in that
// same cycle, so the next transaction may be presented right away. The
// receiver cannot stall the result; it must capture it in that cycle. A
// transaction compares the stored entries in turn and ends early on a
// match: the key store is a single memory read one entry per cycle, and
// its registered read port puts a register between each read and its
// compare. No clearing pass is needed after reset; only entries below the
// fill count are ever compared.

`default_nettype none

module vertex_attribute_dedup_table_unit
  import vadt_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [INDEX_WIDTH-1:0] in_vertex_index,
  input  wire logic signed [INDEX_WIDTH-1:0] in_texcoord_index,
  input  wire logic signed [INDEX_WIDTH-1:0] in_normal_index,
  output logic                               out_valid,
  output logic             [OUT_INDEX_W-1:0] out_unified_index,
  output logic                               out_was_inserted,
  output logic                               out_table_full
);

  vadt_cmd_t    cmd;
  vadt_status_t status;

  // The controller sequences the scan; it leaves the idle state only on an
  // accepted transaction, so start needs no further qualification there.
  vadt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the key store, the fill count, the scan pointer and
  // the registered result.
  vadt_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .vertex_index  (index_t'(in_vertex_index)),
    .texcoord_index(index_t'(in_texcoord_index)),
    .normal_index  (index_t'(in_normal_index)),
    .status        (status),
    .res_valid     (out_valid),
    .res_index     (out_unified_index),
    .res_inserted  (out_was_inserted),
    .res_full      (out_table_full)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/vadt_checker.sv =====
`default_nettype none

module vadt_checker
  import vadt_pkg::*;
(
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic signed [INDEX_WIDTH-1:0] in_vertex_index,
  input wire logic signed [INDEX_WIDTH-1:0] in_texcoord_index,
  input wire logic signed [INDEX_WIDTH-1:0] in_normal_index,
  input wire logic                          out_valid,
  input wire logic             [OUT_INDEX_W-1:0] out_unified_index,
  input wire logic                          out_was_inserted,
  input wire logic                          out_table_full
);

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted transaction");

  // A result is delivered exactly when the block goes idle.
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("block went idle without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result strobe while busy or repeated");

  // Inserted and full never come together, and a full result has index 0.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(out_was_inserted && out_table_full) &&
                   (!out_table_full || (out_unified_index == '0))))
    else $error("inconsistent result flags");

endmodule

bind vertex_attribute_dedup_table_unit vadt_checker u_vadt_checker (.*);

`default_nettype wire
